FILE: design/rrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers, pipeline stage map and the per-stage item record for
// the reflect/refract secondary-ray pipeline.
// ----------------------------------------------------------------------------
package rrr_pkg;

   localparam int FRAC_BITS = 16;

   // Reciprocal divider: 18 quotient bits, 3 per stage
   localparam int DIV_BITS   = 18;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

   // Square root: 24 result digits (top ones zero), 3 per stage
   localparam int SQRT_DIGITS = 24;
   localparam int SQRT_STEPS  = 3;
   localparam int SQRT_STAGES = SQRT_DIGITS / SQRT_STEPS;

   // Stage map
   localparam int ST_IN      = 0;
   localparam int ST_PROD    = 1;
   localparam int ST_COS     = 2;
   localparam int ST_SQR     = 3;
   localparam int ST_REFL    = 4;
   localparam int DIV_FIRST  = 1;
   localparam int ST_RATIO   = DIV_FIRST + DIV_STAGES;
   localparam int ST_MUL     = ST_RATIO + 1;
   localparam int ST_RND     = ST_MUL + 1;
   localparam int ST_TMUL    = ST_RND + 1;
   localparam int ST_CT2     = ST_TMUL + 1;
   localparam int SQRT_FIRST = ST_CT2 + 1;
   localparam int ST_COEF    = SQRT_FIRST + SQRT_STAGES;
   localparam int ST_NMUL    = ST_COEF + 1;
   localparam int ST_OUT     = ST_NMUL + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [15:0] EPS_RESET = 16'd7;
   localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
   localparam logic [18:0] RATIO_MAX = 19'(4 << FRAC_BITS);
   // 2^(2F) / k reaches the 4.0 clamp exactly at this index and below
   localparam logic [17:0] K_CLAMP = 18'(1 << (2 * FRAC_BITS - DIV_BITS));
   // Partial remainder after the bits above the quotient field
   localparam logic [17:0] DIV_R0 = 18'(1 << (2 * FRAC_BITS - DIV_BITS));

   localparam logic signed [63:0] SAT32_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT32_LO = -64'sd2147483648;
   localparam logic signed [63:0] SAT20_HI = 64'sd524287;
   localparam logic signed [63:0] SAT20_LO = -64'sd524288;

   typedef struct packed {
      logic [17:0] r;
      logic [17:0] q;
   } div_type;

   typedef struct packed {
      logic [25:0] rem;
      logic [23:0] root;
   } sqrt_type;

   // One item as it moves down the pipe; fields fill in as stages compute them
   typedef struct packed {
      logic             mode;
      logic             front;
      logic [17:0]      k;
      logic [2:0][31:0] pt;
      logic [2:0][17:0] nv;
      logic [2:0][17:0] iv;
      logic [2:0][35:0] ni;
      logic [20:0]      cos_i;
      logic [41:0]      cc;
      logic [2:0][38:0] rp;
      logic [2:0][35:0] ep;
      logic [24:0]      om;
      logic [2:0][32:0] ro;
      logic [2:0][32:0] fo;
      logic [2:0][23:0] rd;
      div_type          div;
      logic [18:0]      ratio;
      logic [37:0]      n2p;
      logic [40:0]      rcp;
      logic [2:0][37:0] irp;
      logic [20:0]      n2;
      logic [22:0]      rc;
      logic [2:0][20:0] id;
      logic [46:0]      tp;
      logic [29:0]      ct2;
      logic             gt;
      sqrt_type         sq;
      logic [23:0]      coef;
      logic [2:0][41:0] nc;
      logic [2:0][31:0] o;
      logic [2:0][19:0] d;
      logic             tir;
   } item_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } flow_type;

   // floor(v / 2^F + 1/2)
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > SAT32_HI) r = SAT32_HI[31:0];
      else if (v < SAT32_LO) r = SAT32_LO[31:0];
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [19:0] sat20(input logic signed [63:0] v);
      logic [19:0] r;
      if (v > SAT20_HI) r = SAT20_HI[19:0];
      else if (v < SAT20_LO) r = SAT20_LO[19:0];
      else r = v[19:0];
      return r;
   endfunction

   // Restoring division, DIV_STEPS quotient bits
   function automatic div_type div_step(input div_type cur, input logic [17:0] k,
                                        input logic [DIV_STEPS-1:0] bits);
      div_type     nxt;
      logic [18:0] rr;
      nxt = cur;
      for (int b = DIV_STEPS - 1; b >= 0; b--) begin
         rr = {nxt.r, bits[b]};
         if (rr >= {1'b0, k}) begin
            rr    = rr - {1'b0, k};
            nxt.q = {nxt.q[16:0], 1'b1};
         end else begin
            nxt.q = {nxt.q[16:0], 1'b0};
         end
         nxt.r = rr[17:0];
      end
      return nxt;
   endfunction

   // Digit-by-digit integer square root, SQRT_STEPS digits of two bits
   function automatic sqrt_type sqrt_step(input sqrt_type cur,
                                          input logic [2*SQRT_STEPS-1:0] digs);
      sqrt_type    nxt;
      logic [27:0] sh;
      logic [27:0] trial;
      nxt = cur;
      for (int b = SQRT_STEPS - 1; b >= 0; b--) begin
         sh    = {nxt.rem, digs[2*b+1 -: 2]};
         trial = {2'b00, nxt.root, 2'b01};
         if (sh >= trial) begin
            sh       = sh - trial;
            nxt.root = {nxt.root[22:0], 1'b1};
         end else begin
            nxt.root = {nxt.root[22:0], 1'b0};
         end
         nxt.rem = sh[25:0];
      end
      return nxt;
   endfunction

endpackage

FILE: design/ray_reflect_refract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_reflect_refract: secondary ray from a surface hit
// Mirror reflection, or Snell refraction with fallback to reflection on total
// internal reflection, in signed fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one hit per beat (valid/stall), rsp_* one new ray per beat.
//   csr_* writes epsilon (reset value 7); csr_ready is always high. Write it
//   only while no beat is in flight.
//   Throughput is one beat per cycle while rsp_stall stays low. The depth
//   comes from the 1/k divider (six stages of three quotient bits) and the
//   square root of cosT2 (eight stages of three digits), which sit in series
//   with the multipliers. Every stage holds its data while stalled and loads
//   when empty, so a stall on rsp_stall first fills bubbles and only raises
//   req_stall once all 23 stages hold beats. req_stall never depends on
//   req_valid.
//   Reset (synchronous) empties the pipe and restores epsilon; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module ray_reflect_refract (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic               req_front_face,
   input  logic [17:0]        req_refr_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic signed [17:0] req_normal_z,
   input  logic signed [17:0] req_incident_x,
   input  logic signed [17:0] req_incident_y,
   input  logic signed [17:0] req_incident_z,
   // response
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_origin_x,
   output logic signed [31:0] rsp_origin_y,
   output logic signed [31:0] rsp_origin_z,
   output logic signed [19:0] rsp_direction_x,
   output logic signed [19:0] rsp_direction_y,
   output logic signed [19:0] rsp_direction_z,
   output logic               rsp_total_reflection,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);
   import rrr_pkg::*;

   flow_type    flow;
   logic [15:0] eps_ff;
   item_type    pipe_ff [NUM_STAGES];
   item_type    pipe_in [NUM_STAGES];

   // Epsilon register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   rrr_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .flow      (flow)
   );

   assign req_stall = !flow.load[ST_IN];
   assign rsp_valid = flow.valid[ST_OUT];

   // Stage datapath
   always_comb begin : stage_logic
      item_type                p;
      logic signed [63:0]      acc;
      logic signed [63:0]      acc2;
      logic [17:0]             nlo;
      logic [47:0]             sq_val;
      div_type                 dcur;
      sqrt_type                scur;

      for (int i = 1; i < NUM_STAGES; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end

      // capture
      pipe_in[ST_IN]       = '0;
      pipe_in[ST_IN].mode  = req_mode;
      pipe_in[ST_IN].front = req_front_face;
      pipe_in[ST_IN].k     = req_refr_index;
      pipe_in[ST_IN].pt    = {req_point_z, req_point_y, req_point_x};
      pipe_in[ST_IN].nv    = {req_normal_z, req_normal_y, req_normal_x};
      pipe_in[ST_IN].iv    = {req_incident_z, req_incident_y, req_incident_x};

      // N*I products
      p = pipe_ff[ST_PROD-1];
      for (int j = 0; j < 3; j++) begin
         acc = 64'($signed(p.nv[j])) * 64'($signed(p.iv[j]));
         pipe_in[ST_PROD].ni[j] = acc[35:0];
      end

      // cosI = -(N.I)
      p = pipe_ff[ST_COS-1];
      acc = -(64'($signed(p.ni[0])) + 64'($signed(p.ni[1])) + 64'($signed(p.ni[2])));
      acc = rnd(acc);
      pipe_in[ST_COS].cos_i = acc[20:0];

      // cosI^2, N*cosI, N*2eps
      p = pipe_ff[ST_SQR-1];
      acc = 64'($signed(p.cos_i)) * 64'($signed(p.cos_i));
      pipe_in[ST_SQR].cc = acc[41:0];
      for (int j = 0; j < 3; j++) begin
         acc = 64'($signed(p.nv[j])) * 64'($signed(p.cos_i));
         pipe_in[ST_SQR].rp[j] = acc[38:0];
         acc = 64'($signed(p.nv[j])) * $signed(64'({eps_ff, 1'b0}));
         pipe_in[ST_SQR].ep[j] = acc[35:0];
      end

      // 1 - s, both origins, reflect direction
      p = pipe_ff[ST_REFL-1];
      acc = ONE_FX - rnd(64'($signed(p.cc)));
      pipe_in[ST_REFL].om = acc[24:0];
      for (int j = 0; j < 3; j++) begin
         acc2 = rnd(64'($signed(p.ep[j])));
         acc  = 64'($signed(p.pt[j])) + acc2;
         pipe_in[ST_REFL].ro[j] = acc[32:0];
         acc  = 64'($signed(p.pt[j])) - acc2;
         pipe_in[ST_REFL].fo[j] = acc[32:0];
         acc  = rnd(64'($signed(p.rp[j])) <<< 1) + 64'($signed(p.iv[j]));
         pipe_in[ST_REFL].rd[j] = acc[23:0];
      end

      // 1/k divider, numerator 2^(2F) + floor(k/2)
      for (int s = 0; s < DIV_STAGES; s++) begin
         p    = pipe_ff[DIV_FIRST+s-1];
         nlo  = {1'b0, p.k[17:1]};
         dcur = (s == 0) ? '{r: DIV_R0, q: '0} : p.div;
         pipe_in[DIV_FIRST+s].div =
            div_step(dcur, p.k, nlo[DIV_BITS-1-DIV_STEPS*s -: DIV_STEPS]);
      end

      // index ratio: k on back faces, 1/k with clamp at 4.0 on front faces
      p = pipe_ff[ST_RATIO-1];
      if (!p.front) begin
         pipe_in[ST_RATIO].ratio = {1'b0, p.k};
      end else if (p.k <= K_CLAMP) begin
         pipe_in[ST_RATIO].ratio = RATIO_MAX;
      end else begin
         pipe_in[ST_RATIO].ratio = {1'b0, p.div.q};
      end

      // n^2, n*cosI, n*I
      p = pipe_ff[ST_MUL-1];
      acc = 64'(p.ratio) * 64'(p.ratio);
      pipe_in[ST_MUL].n2p = acc[37:0];
      acc = $signed(64'(p.ratio)) * 64'($signed(p.cos_i));
      pipe_in[ST_MUL].rcp = acc[40:0];
      for (int j = 0; j < 3; j++) begin
         acc = $signed(64'(p.ratio)) * 64'($signed(p.iv[j]));
         pipe_in[ST_MUL].irp[j] = acc[37:0];
      end

      p = pipe_ff[ST_RND-1];
      acc = rnd($signed(64'(p.n2p)));
      pipe_in[ST_RND].n2 = acc[20:0];
      acc = rnd(64'($signed(p.rcp)));
      pipe_in[ST_RND].rc = acc[22:0];
      for (int j = 0; j < 3; j++) begin
         acc = rnd(64'($signed(p.irp[j])));
         pipe_in[ST_RND].id[j] = acc[20:0];
      end

      // n^2 * (1 - s)
      p = pipe_ff[ST_TMUL-1];
      acc = $signed(64'(p.n2)) * 64'($signed(p.om));
      pipe_in[ST_TMUL].tp = acc[46:0];

      // cosT2
      p = pipe_ff[ST_CT2-1];
      acc = ONE_FX - rnd(64'($signed(p.tp)));
      pipe_in[ST_CT2].ct2 = acc[29:0];

      // threshold and square root of cosT2 * 2^F
      p = pipe_ff[SQRT_FIRST-1];
      pipe_in[SQRT_FIRST].gt = 64'($signed(p.ct2)) > $signed(64'(eps_ff));
      for (int s = 0; s < SQRT_STAGES; s++) begin
         p      = pipe_ff[SQRT_FIRST+s-1];
         sq_val = 48'(p.ct2[27:0]) << FRAC_BITS;
         scur   = (s == 0) ? '0 : p.sq;
         pipe_in[SQRT_FIRST+s].sq =
            sqrt_step(scur, sq_val[2*SQRT_DIGITS-1-2*SQRT_STEPS*s -: 2*SQRT_STEPS]);
      end

      // n*cosI - sqrt(cosT2)
      p = pipe_ff[ST_COEF-1];
      acc = 64'($signed(p.rc)) - $signed(64'(p.sq.root));
      pipe_in[ST_COEF].coef = acc[23:0];

      p = pipe_ff[ST_NMUL-1];
      for (int j = 0; j < 3; j++) begin
         acc = 64'($signed(p.nv[j])) * 64'($signed(p.coef));
         pipe_in[ST_NMUL].nc[j] = acc[41:0];
      end

      // result select and saturation
      p = pipe_ff[ST_OUT-1];
      pipe_in[ST_OUT].tir = p.mode && !p.gt;
      for (int j = 0; j < 3; j++) begin
         if (!p.mode || !p.gt) begin
            pipe_in[ST_OUT].o[j] = sat32(64'($signed(p.ro[j])));
            pipe_in[ST_OUT].d[j] = sat20(64'($signed(p.rd[j])));
         end else begin
            acc = 64'($signed(p.id[j])) + rnd(64'($signed(p.nc[j])));
            pipe_in[ST_OUT].o[j] = sat32(64'($signed(p.fo[j])));
            pipe_in[ST_OUT].d[j] = sat20(acc);
         end
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (flow.load[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_origin_x         = $signed(pipe_ff[ST_OUT].o[0]);
   assign rsp_origin_y         = $signed(pipe_ff[ST_OUT].o[1]);
   assign rsp_origin_z         = $signed(pipe_ff[ST_OUT].o[2]);
   assign rsp_direction_x      = $signed(pipe_ff[ST_OUT].d[0]);
   assign rsp_direction_y      = $signed(pipe_ff[ST_OUT].d[1]);
   assign rsp_direction_z      = $signed(pipe_ff[ST_OUT].d[2]);
   assign rsp_total_reflection = pipe_ff[ST_OUT].tir;

endmodule

FILE: design/rrr_flow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_flow: pipeline valid bits and stage load enables
// A stage loads when it is empty or the stage after it moves, so bubbles
// collapse under a stall and no beat is dropped or repeated.
// ----------------------------------------------------------------------------
module rrr_flow (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               rsp_stall,
   output rrr_pkg::flow_type  flow
);
   import rrr_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // Load chain from the output back to the input
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   // Valid bits follow their data
   always_comb begin
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign flow.load  = load;
   assign flow.valid = valid_ff;

endmodule

FILE: design/rrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_checker: port-level checks for ray_reflect_refract
// Reset behavior, response hold under stall and the cause of request stall.
// ----------------------------------------------------------------------------
module rrr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_origin_x,
   input logic signed [19:0] rsp_direction_x
);

   // Pipe is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Only a full pipe behind a stalled response backs up the request side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_origin_x) && $stable(rsp_direction_x)))
      else $error("stalled response beat changed");

endmodule

bind ray_reflect_refract rrr_checker u_rrr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_origin_x    (rsp_origin_x),
   .rsp_direction_x (rsp_direction_x)
);
